>>> hdl/svgcsp_pkg.sv
// ----------------------------------------------------------------------------
// SVG color string parser package
// Shared transaction types and result kind codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package svgcsp_pkg;

  typedef enum logic [1:0] {
    KIND_RGB   = 2'd0,
    KIND_HEX   = 2'd1,
    KIND_NAMED = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    kind_t      kind;
    logic       bad_syntax;
  } out_item_t;

endpackage

`default_nettype wire

>>> hdl/svgcsp_core.sv
// ----------------------------------------------------------------------------
// SVG color string parser core
// Per-character parse state and result formation on the last character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svgcsp_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step_en,
  input  wire svgcsp_pkg::in_item_t  item,
  output svgcsp_pkg::out_item_t      result
);

  typedef enum logic [1:0] {
    MODE_START,
    MODE_HEX,
    MODE_RGB,
    MODE_NAMED
  } mode_t;

  typedef struct packed {
    logic       in_number;
    logic [1:0] comp_idx;
    logic [7:0] acc;
    logic [7:0] red;
    logic [7:0] green;
  } dec_t;

  localparam logic [2:0] RGB_OPEN   = 3'd4;
  localparam logic [2:0] RGB_CLOSED = 3'd5;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_LOWER_G = 8'h67;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [11:0] SAT_MAX   = 12'd255;

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0A, 8'h0D};
  endfunction

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd16;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30;
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - 8'h57;
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - 8'h37;
    end
    return d[4:0];
  endfunction

  function automatic logic [7:0] prefix_char(input logic [1:0] idx);
    logic [7:0] p;
    case (idx)
      2'd0:    p = CH_LOWER_R;
      2'd1:    p = CH_LOWER_G;
      2'd2:    p = CH_LOWER_B;
      default: p = CH_LPAREN;
    endcase
    return p;
  endfunction

  function automatic dec_t commit(input dec_t s);
    dec_t o;
    o = s;
    if (s.in_number) begin
      o.in_number = 1'b0;
      case (s.comp_idx)
        2'd0: begin
          o.red      = s.acc;
          o.acc      = '0;
          o.comp_idx = 2'd1;
        end
        2'd1: begin
          o.green    = s.acc;
          o.acc      = '0;
          o.comp_idx = 2'd2;
        end
        2'd2: begin
          o.comp_idx = 2'd3;
        end
        default: o.comp_idx = s.comp_idx;
      endcase
    end
    return o;
  endfunction

  mode_t       mode_r,  mode_nxt;
  dec_t        dec_r,   dec_nxt;
  logic [23:0] hex_r,   hex_nxt;
  logic [2:0]  cnt_r,   cnt_nxt;
  logic        err_r,   err_nxt;

  always_comb begin
    logic [7:0]  c;
    logic [4:0]  nib;
    logic [11:0] prod;
    dec_t        fin;
    c        = item.char_code;
    nib      = hex_nibble(c);
    prod     = ({4'd0, dec_r.acc} << 3) + ({4'd0, dec_r.acc} << 1)
               + {4'd0, c - CH_ZERO};
    mode_nxt = mode_r;
    dec_nxt  = dec_r;
    hex_nxt  = hex_r;
    cnt_nxt  = cnt_r;
    err_nxt  = err_r;
    fin      = dec_r;

    case (mode_r)
      MODE_START: begin
        if (c == CH_HASH) begin
          mode_nxt = MODE_HEX;
        end else if (c == CH_LOWER_R) begin
          mode_nxt = MODE_RGB;
          cnt_nxt  = 3'd1;
        end else if (!is_blank(c)) begin
          mode_nxt = MODE_NAMED;
        end
      end
      MODE_HEX: begin
        if (!nib[4]) begin
          hex_nxt = {hex_r[19:0], nib[3:0]};
          if (cnt_r != 3'd7) begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end else begin
          err_nxt = 1'b1;
        end
      end
      MODE_RGB: begin
        if (cnt_r < RGB_OPEN) begin
          if (cnt_r != 3'd0 && c == prefix_char(cnt_r[1:0])) begin
            cnt_nxt = cnt_r + 3'd1;
          end else begin
            mode_nxt = MODE_NAMED;
          end
        end else if (cnt_r == RGB_CLOSED) begin
          if (!is_blank(c)) begin
            err_nxt = 1'b1;
          end
        end else if (c inside {[8'h30:8'h39]}) begin
          if (dec_r.comp_idx == 2'd3) begin
            err_nxt = 1'b1;
          end else begin
            dec_nxt.acc       = (prod > SAT_MAX) ? 8'hFF : prod[7:0];
            dec_nxt.in_number = 1'b1;
          end
        end else if (c == CH_COMMA || is_blank(c)) begin
          dec_nxt = commit(dec_r);
        end else if (c == CH_RPAREN) begin
          dec_nxt = commit(dec_r);
          cnt_nxt = RGB_CLOSED;
        end else begin
          err_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase

    result.red        = '0;
    result.green      = '0;
    result.blue       = '0;
    result.kind       = svgcsp_pkg::KIND_NAMED;
    result.bad_syntax = err_nxt;

    if (item.last_char) begin
      if (mode_nxt == MODE_HEX) begin
        result.kind = svgcsp_pkg::KIND_HEX;
        if (cnt_nxt == 3'd3) begin
          result.red   = {hex_nxt[11:8], hex_nxt[11:8]};
          result.green = {hex_nxt[7:4], hex_nxt[7:4]};
          result.blue  = {hex_nxt[3:0], hex_nxt[3:0]};
        end else if (cnt_nxt == 3'd6) begin
          result.red   = hex_nxt[23:16];
          result.green = hex_nxt[15:8];
          result.blue  = hex_nxt[7:0];
        end else begin
          result.bad_syntax = 1'b1;
        end
      end else if (mode_nxt == MODE_RGB && cnt_nxt >= RGB_OPEN) begin
        fin         = commit(dec_nxt);
        result.kind = svgcsp_pkg::KIND_RGB;
        if (cnt_nxt != RGB_CLOSED) begin
          result.bad_syntax = 1'b1;
        end
        result.red   = (fin.comp_idx >= 2'd1) ? fin.red   : 8'd0;
        result.green = (fin.comp_idx >= 2'd2) ? fin.green : 8'd0;
        result.blue  = (fin.comp_idx == 2'd3) ? fin.acc   : 8'd0;
      end
      mode_nxt = MODE_START;
      dec_nxt  = '0;
      hex_nxt  = '0;
      cnt_nxt  = '0;
      err_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_START;
      dec_r  <= '0;
      hex_r  <= '0;
      cnt_r  <= '0;
      err_r  <= 1'b0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      dec_r  <= dec_nxt;
      hex_r  <= hex_nxt;
      cnt_r  <= cnt_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/svgcsp_out_fifo.sv
// ----------------------------------------------------------------------------
// SVG color string parser result buffer
// Two-entry result queue that decouples the parser from output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svgcsp_out_fifo (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire svgcsp_pkg::out_item_t  push_data,
  output logic                        not_full,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output svgcsp_pkg::out_item_t       out_data
);

  svgcsp_pkg::out_item_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign not_full  = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/svg_color_string_parser.sv
// ----------------------------------------------------------------------------
// SVG color string parser
// Parses hex, rgb() and named color strings streamed one character per
// transaction; emits one color result on the last character.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload      Handshake
// in_      input      in_item_t    in_valid / in_ready
// out_     output     out_item_t   out_valid / out_ready
//
// One character per cycle sustained unless a last character waits on a full
// result queue; a result is formed from the input register and written to the
// queue, which shows it on out_. Throughput is set by the combinational parse
// step between the input register and the two-entry result queue.
// rst_n clears parse state, the input register valid flag and the result queue.
// An output stall only holds the input side once the queue is full and a
// last character is waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svg_color_string_parser (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire svgcsp_pkg::in_item_t   in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output svgcsp_pkg::out_item_t       out_data
);

  logic                   s1_valid_r;
  svgcsp_pkg::in_item_t   s1_item_r;
  svgcsp_pkg::out_item_t  core_result;
  logic                   fifo_not_full;
  logic                   fire;

  assign fire     = s1_valid_r && (!s1_item_r.last_char || fifo_not_full);
  assign in_ready = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  svgcsp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (fire),
    .item    (s1_item_r),
    .result  (core_result)
  );

  svgcsp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire && s1_item_r.last_char),
    .push_data (core_result),
    .not_full  (fifo_not_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> sim/svgcsp_checker.sv
// ----------------------------------------------------------------------------
// SVG color string parser checker
// Watches both channels of the parser, runs its own color string predictor on
// every accepted character and compares each result transaction, field by
// field, with the oldest predicted color.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svgcsp_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  svgcsp_pkg::in_item_t  in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  svgcsp_pkg::out_item_t out_data,
  output int                    mismatches,
  output int                    colors_waiting,
  output int                    colors_checked
);

  typedef enum logic [1:0] {
    MODE_START,
    MODE_HEX,
    MODE_RGB,
    MODE_NAMED
  } parse_mode_t;

  localparam logic [2:0] RGB_OPEN   = 3'd4;
  localparam logic [2:0] RGB_CLOSED = 3'd5;
  localparam logic [2:0] HEX_SAT    = 3'd7;

  localparam logic [7:0] CH_HASH  = "#";
  localparam logic [7:0] CH_R     = "r";
  localparam logic [7:0] CH_G     = "g";
  localparam logic [7:0] CH_B     = "b";
  localparam logic [7:0] CH_OPEN  = "(";
  localparam logic [7:0] CH_CLOSE = ")";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";

  parse_mode_t mode;
  logic [1:0]  comp_idx;
  logic [8:0]  dec_acc;
  logic        num_open;
  logic [7:0]  red_v;
  logic [7:0]  green_v;
  logic [23:0] hex_v;
  logic [2:0]  prog_cnt;
  logic        err_seen;

  svgcsp_pkg::out_item_t color_q[$];

  initial begin
    mismatches     = 0;
    colors_waiting = 0;
    colors_checked = 0;
  end

  function automatic logic is_blank(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    return 5'd16;
  endfunction

  function automatic logic [7:0] prefix_char(logic [2:0] pos);
    case (pos)
      3'd1:    return CH_G;
      3'd2:    return CH_B;
      default: return CH_OPEN;
    endcase
  endfunction

  task automatic clear_parse();
    mode     = MODE_START;
    comp_idx = 2'd0;
    dec_acc  = 9'd0;
    num_open = 1'b0;
    red_v    = 8'd0;
    green_v  = 8'd0;
    hex_v    = 24'd0;
    prog_cnt = 3'd0;
    err_seen = 1'b0;
  endtask

  task automatic close_number();
    if (num_open) begin
      num_open = 1'b0;
      case (comp_idx)
        2'd0: begin
          red_v    = dec_acc[7:0];
          dec_acc  = 9'd0;
          comp_idx = 2'd1;
        end
        2'd1: begin
          green_v  = dec_acc[7:0];
          dec_acc  = 9'd0;
          comp_idx = 2'd2;
        end
        2'd2: comp_idx = 2'd3;
        default: ;
      endcase
    end
  endtask

  task automatic rgb_step(input logic [7:0] c);
    int sum;
    if (prog_cnt < RGB_OPEN) begin
      if (prog_cnt >= 3'd1 && c == prefix_char(prog_cnt)) prog_cnt = prog_cnt + 3'd1;
      else mode = MODE_NAMED;
    end else if (prog_cnt == RGB_CLOSED) begin
      if (!is_blank(c)) err_seen = 1'b1;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      if (comp_idx == 2'd3) begin
        err_seen = 1'b1;
      end else begin
        sum      = int'(dec_acc) * 10 + int'(c - CH_ZERO);
        dec_acc  = (sum > 255) ? 9'd255 : 9'(sum);
        num_open = 1'b1;
      end
    end else if (c == CH_COMMA || is_blank(c)) begin
      close_number();
    end else if (c == CH_CLOSE) begin
      close_number();
      prog_cnt = RGB_CLOSED;
    end else begin
      err_seen = 1'b1;
    end
  endtask

  task automatic parse_char(input logic [7:0] c, input logic last,
                            output logic emit, output svgcsp_pkg::out_item_t color);
    logic [4:0] nib;
    nib  = hex_nibble(c);
    emit = 1'b0;
    case (mode)
      MODE_START: begin
        if (c == CH_HASH) begin
          mode = MODE_HEX;
        end else if (c == CH_R) begin
          mode     = MODE_RGB;
          prog_cnt = 3'd1;
        end else if (!is_blank(c)) begin
          mode = MODE_NAMED;
        end
      end
      MODE_HEX: begin
        if (nib < 5'd16) begin
          hex_v = {hex_v[19:0], nib[3:0]};
          if (prog_cnt < HEX_SAT) prog_cnt = prog_cnt + 3'd1;
        end else begin
          err_seen = 1'b1;
        end
      end
      MODE_RGB: rgb_step(c);
      default: ;
    endcase

    color = '{red: 8'd0, green: 8'd0, blue: 8'd0, kind: svgcsp_pkg::KIND_NAMED,
              bad_syntax: err_seen};
    if (last) begin
      emit = 1'b1;
      if (mode == MODE_HEX) begin
        color.kind = svgcsp_pkg::KIND_HEX;
        if (prog_cnt == 3'd3) begin
          color.red   = {hex_v[11:8], hex_v[11:8]};
          color.green = {hex_v[7:4], hex_v[7:4]};
          color.blue  = {hex_v[3:0], hex_v[3:0]};
        end else if (prog_cnt == 3'd6) begin
          color.red   = hex_v[23:16];
          color.green = hex_v[15:8];
          color.blue  = hex_v[7:0];
        end else begin
          color.bad_syntax = 1'b1;
        end
      end else if (mode == MODE_RGB && prog_cnt >= RGB_OPEN) begin
        color.kind = svgcsp_pkg::KIND_RGB;
        close_number();
        if (prog_cnt != RGB_CLOSED) color.bad_syntax = 1'b1;
        if (comp_idx >= 2'd1) color.red = red_v;
        if (comp_idx >= 2'd2) color.green = green_v;
        if (comp_idx == 2'd3) color.blue = dec_acc[7:0];
      end
      clear_parse();
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    svgcsp_pkg::out_item_t want;
    svgcsp_pkg::out_item_t next_color;
    logic                  emit;
    if (!rst_n) begin
      clear_parse();
      color_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (color_q.size() == 0) begin
          $error("result transaction with no color pending");
          mismatches++;
        end else begin
          want = color_q.pop_front();
          check_field("red", want.red, out_data.red);
          check_field("green", want.green, out_data.green);
          check_field("blue", want.blue, out_data.blue);
          check_field("kind", 8'(want.kind), 8'(out_data.kind));
          check_field("bad_syntax", 8'(want.bad_syntax), 8'(out_data.bad_syntax));
          colors_checked++;
        end
      end
      if (in_valid && in_ready) begin
        parse_char(in_data.char_code, in_data.last_char, emit, next_color);
        if (emit) color_q.push_back(next_color);
      end
    end
    colors_waiting = color_q.size();
  end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// SVG color string parser testbench
// Streams directed and random color strings (hex, rgb(), named, noise and
// corrupted forms) into the parser under three sender/receiver idle mixes;
// a side checker predicts and compares every color result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  svgcsp_pkg::in_item_t  in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  svgcsp_pkg::out_item_t out_data;

  int        mismatches;
  int        colors_waiting;
  int        colors_checked;
  int        chars_sent     = 0;
  int        sender_idle    = 0;
  int        receiver_idle  = 0;
  logic [7:0] text_q[$];

  localparam string HEX_DIGITS = "0123456789abcdefABCDEF";
  localparam string BLANKS     = " \t\r\n";

  svg_color_string_parser i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  svgcsp_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .mismatches    (mismatches),
    .colors_waiting(colors_waiting),
    .colors_checked(colors_checked)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_idle);
  end

  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

  task automatic add_text(input string t);
    for (int i = 0; i < t.len(); i++) text_q.push_back(t[i]);
  endtask

  task automatic add_blanks(input int n);
    for (int i = 0; i < n; i++) text_q.push_back(BLANKS[$urandom_range(3)]);
  endtask

  // Call at a falling edge; returns at the falling edge after the transaction.
  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{char_code: c, last_char: last};
    do @(posedge clk); while (!in_ready);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic build_hex();
    int n;
    n = ($urandom_range(99) < 85) ? (($urandom_range(1) != 0) ? 6 : 3) : $urandom_range(9);
    text_q.push_back("#");
    for (int i = 0; i < n; i++) text_q.push_back(HEX_DIGITS[$urandom_range(21)]);
  endtask

  task automatic build_rgb();
    int n;
    int v;
    n = ($urandom_range(99) < 80) ? 3 : $urandom_range(4);
    add_text("rgb(");
    add_blanks($urandom_range(2));
    for (int i = 0; i < n; i++) begin
      v = ($urandom_range(9) == 0) ? $urandom_range(9999) : $urandom_range(300);
      add_text($sformatf("%0d", v));
      if (i != n - 1) begin
        if ($urandom_range(1) != 0) text_q.push_back(",");
        add_blanks($urandom_range(2));
        if (text_q[text_q.size() - 1] != ",") text_q.push_back(" ");
      end
    end
    add_blanks($urandom_range(1));
    if ($urandom_range(9) != 0) text_q.push_back(")");
    add_blanks($urandom_range(1));
  endtask

  task automatic build_named();
    case ($urandom_range(5))
      0:       add_text("red");
      1:       add_text("rgba(1,2,3)");
      2:       add_text("rgb");
      3:       add_text("rGb(4,5,6)");
      4:       add_text("none");
      default: add_text("steelblue");
    endcase
  endtask

  task automatic build_noise();
    int n;
    n = $urandom_range(8, 1);
    for (int i = 0; i < n; i++) text_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic run_random(input int char_budget);
    int stop_at;
    int pick;
    stop_at = chars_sent + char_budget;
    while (chars_sent < stop_at) begin
      add_blanks(($urandom_range(4) == 0) ? $urandom_range(3, 1) : 0);
      pick = $urandom_range(99);
      if (pick < 35) build_hex();
      else if (pick < 75) build_rgb();
      else if (pick < 87) build_named();
      else build_noise();
      // corrupt one character of some strings
      if ($urandom_range(99) < 15) begin
        text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
      end
      send_text();
    end
  endtask

  initial begin
    int drain;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    sender_idle   = 18;
    receiver_idle = 71;
    add_text("#FfF");                send_text();
    add_text("#00aB9f");             send_text();
    add_text(" \t\r\n#123");         send_text();
    add_text(" ");                   send_text();
    add_text("red");                 send_text();
    add_text("rGb(1,2,3)");          send_text();
    add_text("#12g4");               send_text();
    add_text("#1234");               send_text();
    add_text("#1234567");            send_text();
    add_text("rgb(255,0,128)");      send_text();
    add_text("rgb( 300 1000 , 7 )"); send_text();
    add_text("rgb(-1,2,3)");         send_text();
    add_text("rgb(1,2,3,4)");        send_text();
    add_text("rgb(1,2,3) x");        send_text();
    add_text("rgb(9,8,7)  ");        send_text();
    add_text("rgb(10,20");           send_text();
    add_text("rgb(");                send_text();
    add_text("rgb()");               send_text();
    add_text("r");                   send_text();
    add_text("blue#");               send_text();
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    send_text();

    run_random(110);
    sender_idle   = 71;
    receiver_idle = 18;
    run_random(110);
    sender_idle   = 0;
    receiver_idle = 0;
    run_random(110);
    in_valid <= 1'b0;

    while (colors_waiting != 0) @(posedge clk);
    drain = 0;
    while (drain < 10) begin
      @(posedge clk);
      drain++;
    end

    $display("summary: %0d characters sent, %0d color results checked", chars_sent,
             colors_checked);
    $display("summary: hex, rgb(), named, noise and corrupted strings over three idle mixes");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
